### sv/barycentric_texcoord_interp_core_defines.svh
// Assertion macros for the barycentric texcoord interpolator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BARYCENTRIC_TEXCOORD_INTERP_CORE_DEFINES_SVH
`define BARYCENTRIC_TEXCOORD_INTERP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BTCI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/btci_pkg.sv
// Shared types and constants for the barycentric texcoord interpolator.
// No dependencies; used by btci_div and the top level.
package btci_pkg;

    localparam int POS_WIDTH = 48;
    localparam int UVP_WIDTH = 32;
    localparam int UV_BITS   = 16;
    localparam int UV_FRAC   = 12;

    localparam logic [UV_BITS-1:0] UV_MAX    = 16'h7FFF;
    localparam logic [UV_BITS-1:0] UV_MIN    = 16'h8000;
    localparam logic [UV_BITS-1:0] FRAC_MASK = UV_BITS'((1 << UV_FRAC) - 1);

    typedef enum logic
    {
        OP_RAW  = 1'b0,
        OP_WRAP = 1'b1
    } op_t;

    // Per-beat control that rides alongside the divider lanes
    typedef struct packed
    {
        op_t  op;
        logic degen;
        logic neg_u;
        logic neg_v;
    } ctrl_t;

    // Low quotient bits plus a sticky flag for any higher bit
    typedef struct packed
    {
        logic               ovf;
        logic [UV_BITS-1:0] quo;
    } quo_t;

endpackage

### sv/barycentric_texcoord_interp_core.sv
// Top level of the barycentric texcoord interpolator.
// Depends on btci_pkg, btci_div and barycentric_texcoord_interp_core_defines.svh.
//
// Takes one triangle (three positions, three u,v pairs) and a point per beat and
// returns the interpolated u,v in signed Q4.12, rounded to nearest, saturated in raw
// mode or reduced to the fraction 0..4095 in wrap mode; a triangle with zero area
// gives zeros with ok low. A new beat is taken every cycle while no held result stalls
// the input. The edge, cross, dot and weighting arithmetic stages come first, then
// one restoring-divider stage per quotient bit (4*COORD_WIDTH + 27 bits), and then the
// output register. The divider depth sets latency.
// A stall on the result side freezes the whole pipeline in place.

`include "barycentric_texcoord_interp_core_defines.svh"

module barycentric_texcoord_interp_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 operation,
    input  logic [btci_pkg::POS_WIDTH-1:0]       vertex_a_pos,
    input  logic [btci_pkg::POS_WIDTH-1:0]       vertex_b_pos,
    input  logic [btci_pkg::POS_WIDTH-1:0]       vertex_c_pos,
    input  logic [btci_pkg::POS_WIDTH-1:0]       point_pos,
    input  logic [btci_pkg::UVP_WIDTH-1:0]       vertex_a_uv,
    input  logic [btci_pkg::UVP_WIDTH-1:0]       vertex_b_uv,
    input  logic [btci_pkg::UVP_WIDTH-1:0]       vertex_c_uv,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [btci_pkg::UV_BITS-1:0]  tex_u,
    output logic signed [btci_pkg::UV_BITS-1:0]  tex_v,
    output logic                                 ok
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;            // edge / offset components
    localparam int NW   = 2 * EW + 1;        // cross product components
    localparam int HL   = (NW + 1) / 2;      // low half of a split operand
    localparam int PW   = 2 * HL + 2;        // partial product of two halves
    localparam int PRW  = 2 * NW;            // full component product
    localparam int DW   = PRW + 2;           // dot products and weights
    localparam int KW   = DW / 4;            // weight chunk
    localparam int UB   = btci_pkg::UV_BITS;
    localparam int WPW  = KW + 1 + UB;       // chunk times texcoord
    localparam int MW   = DW + UB + 2;       // interpolated numerator
    localparam int TW   = MW + 1;            // rounded dividend
    localparam int EXTW = btci_pkg::POS_WIDTH + 3 * CW;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic signed [EW-1:0] sdiff(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
        return EW'(x) - EW'(y);
    endfunction

    function automatic logic signed [NW-1:0] xterm(input logic signed [EW-1:0] p,
                                                   input logic signed [EW-1:0] q,
                                                   input logic signed [EW-1:0] r,
                                                   input logic signed [EW-1:0] t);
        logic signed [2*EW-1:0] m0;
        logic signed [2*EW-1:0] m1;
        m0 = p * q;
        m1 = r * t;
        return NW'(m0) - NW'(m1);
    endfunction

    function automatic logic signed [HL:0] half_lo(input logic signed [NW-1:0] x);
        return $signed({1'b0, x[HL-1:0]});
    endfunction

    function automatic logic signed [HL:0] half_hi(input logic signed [NW-1:0] x);
        return (HL+1)'($signed(x[NW-1:HL]));
    endfunction

    // top chunk carries the sign, the others are unsigned
    function automatic logic signed [KW:0] wchunk(input logic signed [DW-1:0] w,
                                                  input int j);
        logic ext;
        ext = (j == 3) ? w[DW-1] : 1'b0;
        return $signed({ext, w[j*KW +: KW]});
    endfunction

    function automatic logic [UB-1:0] lane_finish(input btci_pkg::quo_t qv,
                                                  input logic neg,
                                                  input btci_pkg::op_t op);
        logic [UB-1:0] sgn;
        logic [UB-1:0] res;
        sgn = neg ? (UB'(0) - qv.quo) : qv.quo;
        case (op)
            btci_pkg::OP_WRAP:
                res = sgn & btci_pkg::FRAC_MASK;
            btci_pkg::OP_RAW:
            begin
                if (neg)
                    res = (qv.ovf || qv.quo > btci_pkg::UV_MIN) ? btci_pkg::UV_MIN : sgn;
                else
                    res = (qv.ovf || qv.quo > btci_pkg::UV_MAX) ? btci_pkg::UV_MAX : sgn;
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // flow control: whole pipeline moves unless the output beat is held
    // ------------------------------------------------------------------
    logic en;
    logic result_valid_reg;
    logic [9:0] vld_reg;

    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[8:0], item_valid};
    end

    // op and texcoords ride along until they are used
    btci_pkg::op_t           op_reg [9];
    logic [btci_pkg::UVP_WIDTH-1:0] uv_reg [6][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]    <= btci_pkg::op_t'(operation);
            uv_reg[0][0] <= vertex_a_uv;
            uv_reg[0][1] <= vertex_b_uv;
            uv_reg[0][2] <= vertex_c_uv;
            for (int i = 1; i < 9; i++)
                op_reg[i] <= op_reg[i-1];
            for (int i = 1; i < 6; i++)
                uv_reg[i] <= uv_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: unpack coordinates, edges and offsets from the point
    // ------------------------------------------------------------------
    logic [EXTW-1:0]        pos_ext [4];
    logic signed [CW-1:0]   crd     [4][3];
    logic signed [EW-1:0]   e1_reg [3], e1_next [3];
    logic signed [EW-1:0]   e2_reg [3], e2_next [3];
    logic signed [EW-1:0]   bp_reg [3], bp_next [3];
    logic signed [EW-1:0]   cp_reg [3], cp_next [3];
    logic signed [EW-1:0]   ap_reg [3], ap_next [3];

    assign pos_ext[0] = EXTW'(vertex_a_pos);
    assign pos_ext[1] = EXTW'(vertex_b_pos);
    assign pos_ext[2] = EXTW'(vertex_c_pos);
    assign pos_ext[3] = EXTW'(point_pos);

    genvar v, k, m, i, j, l;
    generate
        for (v = 0; v < 4; v++)
        begin : g_unpack
            for (k = 0; k < 3; k++)
            begin : g_axis
                assign crd[v][k] = $signed(pos_ext[v][k*CW +: CW]);
            end
        end

        for (k = 0; k < 3; k++)
        begin : g_s1
            assign e1_next[k] = sdiff(crd[1][k], crd[0][k]);
            assign e2_next[k] = sdiff(crd[2][k], crd[0][k]);
            assign bp_next[k] = sdiff(crd[1][k], crd[3][k]);
            assign cp_next[k] = sdiff(crd[2][k], crd[3][k]);
            assign ap_next[k] = sdiff(crd[0][k], crd[3][k]);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            bp_reg <= bp_next;
            cp_reg <= cp_next;
            ap_reg <= ap_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: normal N and the two sub-triangle cross products
    // ------------------------------------------------------------------
    logic signed [NW-1:0] cr_reg [3][3], cr_next [3][3];

    generate
        for (k = 0; k < 3; k++)
        begin : g_s2
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;
            assign cr_next[0][k] = xterm(e1_reg[K1], e2_reg[K2], e1_reg[K2], e2_reg[K1]);
            assign cr_next[1][k] = xterm(bp_reg[K1], cp_reg[K2], bp_reg[K2], cp_reg[K1]);
            assign cr_next[2][k] = xterm(cp_reg[K1], ap_reg[K2], cp_reg[K2], ap_reg[K1]);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            cr_reg <= cr_next;
    end

    // ------------------------------------------------------------------
    // stage 3: half-width partial products of N against each vector
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pp_reg [3][3][4], pp_next [3][3][4];

    generate
        for (m = 0; m < 3; m++)
        begin : g_s3
            for (k = 0; k < 3; k++)
            begin : g_axis
                assign pp_next[m][k][0] = half_lo(cr_reg[0][k]) * half_lo(cr_reg[m][k]);
                assign pp_next[m][k][1] = half_lo(cr_reg[0][k]) * half_hi(cr_reg[m][k]);
                assign pp_next[m][k][2] = half_hi(cr_reg[0][k]) * half_lo(cr_reg[m][k]);
                assign pp_next[m][k][3] = half_hi(cr_reg[0][k]) * half_hi(cr_reg[m][k]);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            pp_reg <= pp_next;
    end

    // ------------------------------------------------------------------
    // stage 4: recombine the partials into full component products
    // ------------------------------------------------------------------
    logic signed [PRW-1:0] prod_reg [3][3], prod_next [3][3];

    generate
        for (m = 0; m < 3; m++)
        begin : g_s4
            for (k = 0; k < 3; k++)
            begin : g_axis
                assign prod_next[m][k] = (PRW'(pp_reg[m][k][3]) <<< (2 * HL))
                                       + ((PRW'(pp_reg[m][k][1]) + PRW'(pp_reg[m][k][2])) <<< HL)
                                       + PRW'(pp_reg[m][k][0]);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    // ------------------------------------------------------------------
    // stage 5: dot products: N.N, wa, wb
    // ------------------------------------------------------------------
    logic signed [DW-1:0] dot_reg [3], dot_next [3];

    generate
        for (m = 0; m < 3; m++)
        begin : g_s5
            assign dot_next[m] = DW'(prod_reg[m][0]) + DW'(prod_reg[m][1])
                               + DW'(prod_reg[m][2]);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            dot_reg <= dot_next;
    end

    // ------------------------------------------------------------------
    // stage 6: third weight from the other two, degenerate check
    // ------------------------------------------------------------------
    logic signed [DW-1:0] w_reg [3], w_next [3];
    logic signed [DW-1:0] dcar_reg [4];
    logic                 degen_reg [4];

    assign w_next[0] = dot_reg[1];
    assign w_next[1] = dot_reg[2];
    assign w_next[2] = dot_reg[0] - dot_reg[1] - dot_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg        <= w_next;
            dcar_reg[0]  <= dot_reg[0];
            degen_reg[0] <= (dot_reg[0] == '0);
            for (int s = 1; s < 4; s++)
            begin
                dcar_reg[s]  <= dcar_reg[s-1];
                degen_reg[s] <= degen_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 7: weight chunks times texcoords
    // ------------------------------------------------------------------
    logic signed [WPW-1:0] wp_reg [3][4][2], wp_next [3][4][2];

    generate
        for (i = 0; i < 3; i++)
        begin : g_s7
            for (j = 0; j < 4; j++)
            begin : g_chunk
                for (l = 0; l < 2; l++)
                begin : g_lane
                    assign wp_next[i][j][l] = wchunk(w_reg[i], j)
                                            * $signed(uv_reg[5][i][l*UB +: UB]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            wp_reg <= wp_next;
    end

    // ------------------------------------------------------------------
    // stage 8: per-vertex weighted texcoord
    // ------------------------------------------------------------------
    logic signed [MW-1:0] lp_reg [3][2], lp_next [3][2];

    generate
        for (i = 0; i < 3; i++)
        begin : g_s8
            for (l = 0; l < 2; l++)
            begin : g_lane
                assign lp_next[i][l] = MW'(wp_reg[i][0][l])
                                     + (MW'(wp_reg[i][1][l]) <<< KW)
                                     + (MW'(wp_reg[i][2][l]) <<< (2 * KW))
                                     + (MW'(wp_reg[i][3][l]) <<< (3 * KW));
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            lp_reg <= lp_next;
    end

    // ------------------------------------------------------------------
    // stage 9: u and v numerators
    // ------------------------------------------------------------------
    logic signed [MW-1:0] num_reg [2], num_next [2];

    generate
        for (l = 0; l < 2; l++)
        begin : g_s9
            assign num_next[l] = lp_reg[0][l] + lp_reg[1][l] + lp_reg[2][l];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            num_reg <= num_next;
    end

    // ------------------------------------------------------------------
    // stage 10: sign/magnitude, rounding bias: t = 2|num| + D over 2D
    // ------------------------------------------------------------------
    logic [TW-1:0]       t_reg [2], t_next [2];
    logic [MW-1:0]       sel   [2];
    logic                neg   [2];
    logic [DW-1:0]       den_reg, den_next;
    btci_pkg::ctrl_t     ctrl_reg, ctrl_next;

    generate
        for (l = 0; l < 2; l++)
        begin : g_s10
            assign neg[l]    = num_reg[l][MW-1];
            assign sel[l]    = neg[l] ? ~num_reg[l] : num_reg[l];
            assign t_next[l] = {sel[l], 1'b0} + TW'($unsigned(dcar_reg[3]))
                             + (neg[l] ? TW'(2) : TW'(0));
        end
    endgenerate

    assign den_next        = {dcar_reg[3][DW-2:0], 1'b0};
    assign ctrl_next.op    = op_reg[8];
    assign ctrl_next.degen = degen_reg[3];
    assign ctrl_next.neg_u = neg[0];
    assign ctrl_next.neg_v = neg[1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t_next;
            den_reg  <= den_next;
            ctrl_reg <= ctrl_next;
        end
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    logic            div_done;
    btci_pkg::ctrl_t div_ctrl;
    btci_pkg::quo_t  div_quo_u;
    btci_pkg::quo_t  div_quo_v;

    btci_div #(
        .DEN_WIDTH (DW),
        .NUM_WIDTH (TW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (vld_reg[9]),
        .ctrl      (ctrl_reg),
        .den       (den_reg),
        .num_u     (t_reg[0]),
        .num_v     (t_reg[1]),
        .done      (div_done),
        .done_ctrl (div_ctrl),
        .quo_u     (div_quo_u),
        .quo_v     (div_quo_v)
    );

    // ------------------------------------------------------------------
    // output register: saturate or wrap, zero on a degenerate triangle
    // ------------------------------------------------------------------
    logic [UB-1:0]   tex_u_reg, tex_u_next;
    logic [UB-1:0]   tex_v_reg, tex_v_next;
    logic            ok_reg, ok_next;
    btci_pkg::op_t   out_op_reg;

    always_comb
    begin
        if (div_ctrl.degen)
        begin
            tex_u_next = '0;
            tex_v_next = '0;
            ok_next    = 1'b0;
        end
        else
        begin
            tex_u_next = lane_finish(div_quo_u, div_ctrl.neg_u, div_ctrl.op);
            tex_v_next = lane_finish(div_quo_v, div_ctrl.neg_v, div_ctrl.op);
            ok_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= div_done;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tex_u_reg  <= tex_u_next;
            tex_v_reg  <= tex_v_next;
            ok_reg     <= ok_next;
            out_op_reg <= div_ctrl.op;
        end
    end

    assign result_valid = result_valid_reg;
    assign tex_u        = $signed(tex_u_reg);
    assign tex_v        = $signed(tex_v_reg);
    assign ok           = ok_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BTCI_ASSERT_IMPLY(a_stall_back, result_valid && result_stall, item_stall, "held result did not stall input")
    `BTCI_ASSERT_NEXT(a_accept_enters, item_valid && !item_stall, vld_reg[0], "accepted beat missing from first stage")
    `BTCI_ASSERT_IMPLY(a_degen_zero, result_valid && !ok, tex_u == 16'sd0 && tex_v == 16'sd0, "degenerate result not zero")
    `BTCI_ASSERT_IMPLY(a_wrap_range, result_valid && ok && out_op_reg == btci_pkg::OP_WRAP, tex_u[15:12] == 4'd0 && tex_v[15:12] == 4'd0, "wrapped result out of range")

endmodule

### sv/btci_div.sv
// Pipelined restoring divider, two lanes sharing one divisor.
// One quotient bit per stage; depends on btci_pkg.
module btci_div #(
    parameter int DEN_WIDTH = 72,
    parameter int NUM_WIDTH = 91
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid,
    input  btci_pkg::ctrl_t        ctrl,
    input  logic [DEN_WIDTH-1:0]   den,
    input  logic [NUM_WIDTH-1:0]   num_u,
    input  logic [NUM_WIDTH-1:0]   num_v,
    output logic                   done,
    output btci_pkg::ctrl_t        done_ctrl,
    output btci_pkg::quo_t         quo_u,
    output btci_pkg::quo_t         quo_v
);

    localparam int NS = NUM_WIDTH;

    logic                 vld_reg  [NS];
    btci_pkg::ctrl_t      ctrl_reg [NS];
    logic [DEN_WIDTH-1:0] den_reg  [NS];
    logic [NUM_WIDTH-1:0] num_reg  [NS][2];
    logic [DEN_WIDTH-1:0] rem_reg  [NS][2];
    btci_pkg::quo_t       quo_reg  [NS][2];

    genvar s, l;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            logic                 vld_prev;
            btci_pkg::ctrl_t      ctrl_prev;
            logic [DEN_WIDTH-1:0] den_prev;
            logic [NUM_WIDTH-1:0] num_prev [2];
            logic [DEN_WIDTH-1:0] rem_prev [2];
            btci_pkg::quo_t       quo_prev [2];

            // stage inputs: port values for the first stage, else previous stage
            if (s == 0)
            begin : g_first
                always_comb
                begin
                    vld_prev    = valid;
                    ctrl_prev   = ctrl;
                    den_prev    = den;
                    num_prev[0] = num_u;
                    num_prev[1] = num_v;
                    rem_prev[0] = '0;
                    rem_prev[1] = '0;
                    quo_prev[0] = '0;
                    quo_prev[1] = '0;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    vld_prev    = vld_reg[s-1];
                    ctrl_prev   = ctrl_reg[s-1];
                    den_prev    = den_reg[s-1];
                    num_prev[0] = num_reg[s-1][0];
                    num_prev[1] = num_reg[s-1][1];
                    rem_prev[0] = rem_reg[s-1][0];
                    rem_prev[1] = rem_reg[s-1][1];
                    quo_prev[0] = quo_reg[s-1][0];
                    quo_prev[1] = quo_reg[s-1][1];
                end
            end

            // shared control and divisor
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (en)
                    vld_reg[s] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ctrl_reg[s] <= ctrl_prev;
                    den_reg[s]  <= den_prev;
                end
            end

            for (l = 0; l < 2; l++)
            begin : g_lane
                logic [DEN_WIDTH:0]   rem_sh;
                logic                 ge;
                logic [NUM_WIDTH-1:0] num_next;
                logic [DEN_WIDTH-1:0] rem_next;
                btci_pkg::quo_t       quo_next;

                // shift in the next dividend bit, trial subtract
                always_comb
                begin
                    rem_sh   = {rem_prev[l], num_prev[l][NUM_WIDTH-1]};
                    ge       = (rem_sh >= {1'b0, den_prev});
                    rem_next = ge ? DEN_WIDTH'(rem_sh - {1'b0, den_prev})
                                  : rem_sh[DEN_WIDTH-1:0];
                    num_next = num_prev[l] << 1;
                    quo_next.quo = {quo_prev[l].quo[btci_pkg::UV_BITS-2:0], ge};
                    quo_next.ovf = quo_prev[l].ovf | quo_prev[l].quo[btci_pkg::UV_BITS-1];
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        num_reg[s][l] <= num_next;
                        rem_reg[s][l] <= rem_next;
                        quo_reg[s][l] <= quo_next;
                    end
                end
            end
        end
    endgenerate

    assign done      = vld_reg[NS-1];
    assign done_ctrl = ctrl_reg[NS-1];
    assign quo_u     = quo_reg[NS-1][0];
    assign quo_v     = quo_reg[NS-1][1];

endmodule
